### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers
// shared macros for the concurrent checks in the rtl folder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset held off
`define KCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen
`define KCL_ASSERT_NEVER(lbl, cond, msg) \
  `KCL_ASSERT(lbl, !(cond), msg)

`endif

### rtl/kcl_pkg.sv
// ---------------------------------------------------------------------------
// keypad code lock package
// types, codes and reset constants shared by the lock controller modules
// ---------------------------------------------------------------------------
package kcl_pkg;

  localparam int unsigned POS_W = 4;

  // request kinds
  localparam logic [1:0] FUNC_KEY    = 2'd0;
  localparam logic [1:0] FUNC_SECOND = 2'd1;
  localparam logic [1:0] FUNC_LIGHT  = 2'd2;
  localparam logic [1:0] FUNC_TOUCH  = 2'd3;

  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  // configuration register indexes
  localparam logic [2:0] CFG_MASTER_CODE     = 3'd0;
  localparam logic [2:0] CFG_FAIL_LIMIT      = 3'd1;
  localparam logic [2:0] CFG_LOCKOUT_STEP    = 3'd2;
  localparam logic [2:0] CFG_LIGHT_TICKS     = 3'd3;
  localparam logic [2:0] CFG_TOUCH_THRESHOLD = 3'd4;

  localparam logic [39:0] MASTER_RESET    = 40'h20821997CD;
  localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd5;
  localparam logic [3:0]  LOCK_STEP_RST   = 4'd5;
  localparam logic [7:0]  LIGHT_TICKS_RST = 8'd120;
  localparam logic [15:0] TOUCH_THR_RST   = 16'd15000;

  // phase codes as seen on the result
  localparam logic [2:0] PHC_IDLE    = 3'd0;
  localparam logic [2:0] PHC_UNLOCK  = 3'd1;
  localparam logic [2:0] PHC_CHECK   = 3'd2;
  localparam logic [2:0] PHC_NEW     = 3'd3;
  localparam logic [2:0] PHC_CONFIRM = 3'd4;
  localparam logic [2:0] PHC_LOCKED  = 3'd5;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_UNLOCK  = 6'b000010,
    PH_CHECK   = 6'b000100,
    PH_NEW     = 6'b001000,
    PH_CONFIRM = 6'b010000,
    PH_LOCKED  = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_OPENED     = 3'd1,
    EV_WRONG      = 3'd2,
    EV_CHANGED    = 3'd3,
    EV_DIFFER     = 3'd4,
    EV_LOCK_BEGIN = 3'd5,
    EV_LOCK_OVER  = 3'd6
  } event_e;

  typedef struct packed {
    logic [39:0] master_code;
    logic [7:0]  fail_limit;
    logic [3:0]  lockout_step;
    logic [7:0]  light_ticks;
    logic [15:0] touch_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       failures;
    logic [11:0]      lockout_left;
    logic [POS_W-1:0] digits_entered;
    logic [2:0]       phase;
    logic             light_on;
    event_e           event_res;
  } res_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:    code = PHC_IDLE;
      PH_UNLOCK:  code = PHC_UNLOCK;
      PH_CHECK:   code = PHC_CHECK;
      PH_NEW:     code = PHC_NEW;
      PH_CONFIRM: code = PHC_CONFIRM;
      PH_LOCKED:  code = PHC_LOCKED;
      default:    code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

### rtl/kcl_cfg.sv
// ---------------------------------------------------------------------------
// lock configuration registers
// holds master code, failure limit, lockout step, light timeout, threshold
// ---------------------------------------------------------------------------
module kcl_cfg import kcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MASTER_CODE:     cfg_d.master_code     = cfg_data_i;
        CFG_FAIL_LIMIT:      cfg_d.fail_limit      = cfg_data_i[7:0];
        CFG_LOCKOUT_STEP:    cfg_d.lockout_step    = cfg_data_i[3:0];
        CFG_LIGHT_TICKS:     cfg_d.light_ticks     = cfg_data_i[7:0];
        CFG_TOUCH_THRESHOLD: cfg_d.touch_threshold = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_code     <= MASTER_RESET;
      cfg_q.fail_limit      <= FAIL_LIMIT_RST;
      cfg_q.lockout_step    <= LOCK_STEP_RST;
      cfg_q.light_ticks     <= LIGHT_TICKS_RST;
      cfg_q.touch_threshold <= TOUCH_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/kcl_core.sv
// ---------------------------------------------------------------------------
// lock state core
// lock state registers and the single-pass update for one request
// ---------------------------------------------------------------------------
module kcl_core import kcl_pkg::*; #(
  parameter int unsigned CODE_LEN = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [1:0]  func_i,
  input  logic [3:0]  key_i,
  input  logic [15:0] level_i,
  input  cfg_t        cfg_i,
  output res_t        res_o
);

  localparam int unsigned CW = 4 * CODE_LEN;

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]    entry_q, entry_d;
  logic [CW-1:0]    first_q, first_d;
  logic [CW-1:0]    stored_q, stored_d;
  logic [7:0]       fail_q, fail_d;
  logic [11:0]      lock_q, lock_d;
  logic             light_q, light_d;
  logic [7:0]       timer_q, timer_d;

  logic             is_digit, done;
  logic [CW-1:0]    shifted, master_ext;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       fail_inc;
  logic [11:0]      lock_dec;
  event_e           ev;

  // master code register is 40 bits; shorter codes use its low keys
  assign master_ext = CW'(cfg_i.master_code);
  assign is_digit   = (key_i != KEY_STAR) && (key_i != KEY_HASH);
  assign shifted    = (entry_q << 4) | CW'(key_i);
  assign done       = is_digit && (pos_q == POS_W'(CODE_LEN - 1));
  assign pos_next   = done ? '0 : pos_q + 1'b1;
  assign fail_inc   = (fail_q != 8'hFF) ? fail_q + 8'd1 : fail_q;
  assign lock_dec   = (lock_q != '0) ? lock_q - 12'd1 : lock_q;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    entry_d  = entry_q;
    first_d  = first_q;
    stored_d = stored_q;
    fail_d   = fail_q;
    lock_d   = lock_q;
    light_d  = light_q;
    timer_d  = timer_q;
    ev       = EV_NONE;

    case (func_i)
      FUNC_KEY: begin
        if (phase_q != PH_LOCKED) begin
          light_d = 1'b1;
          timer_d = '0;
          if (phase_q != PH_IDLE && is_digit) begin
            entry_d = shifted;
            pos_d   = pos_next;
          end
          case (phase_q)
            PH_IDLE: begin
              phase_d = (key_i == KEY_STAR) ? PH_CHECK : PH_UNLOCK;
              pos_d   = '0;
              entry_d = '0;
            end
            PH_UNLOCK: begin
              if (done) begin
                phase_d = PH_IDLE;
                if (shifted == stored_q) begin
                  fail_d = '0;
                  ev     = EV_OPENED;
                end else begin
                  fail_d = fail_inc;
                  ev     = EV_WRONG;
                  if (fail_inc > cfg_i.fail_limit && cfg_i.lockout_step != '0) begin
                    lock_d  = 12'(cfg_i.lockout_step) * 12'(fail_inc);
                    phase_d = PH_LOCKED;
                    ev      = EV_LOCK_BEGIN;
                  end
                end
              end
            end
            PH_CHECK: begin
              if (done) begin
                if (shifted == stored_q || shifted == master_ext) begin
                  phase_d = PH_NEW;
                  entry_d = '0;
                end else begin
                  phase_d = PH_IDLE;
                  ev      = EV_WRONG;
                end
              end
            end
            PH_NEW: begin
              if (done) begin
                first_d = shifted;
                entry_d = '0;
                phase_d = PH_CONFIRM;
              end
            end
            PH_CONFIRM: begin
              if (done) begin
                phase_d = PH_IDLE;
                if (shifted == first_q) begin
                  stored_d = shifted;
                  ev       = EV_CHANGED;
                end else begin
                  ev = EV_DIFFER;
                end
              end
            end
            default: ;
          endcase
        end
      end
      FUNC_SECOND: begin
        if (phase_q == PH_LOCKED) begin
          lock_d = lock_dec;
          if (lock_dec == '0) begin
            phase_d = PH_IDLE;
            ev      = EV_LOCK_OVER;
          end
        end
      end
      FUNC_LIGHT: begin
        if (light_q) begin
          if (timer_q > cfg_i.light_ticks) begin
            timer_d = '0;
            light_d = 1'b0;
          end else if (timer_q != 8'hFF) begin
            timer_d = timer_q + 8'd1;
          end
        end
      end
      FUNC_TOUCH: begin
        if (level_i < cfg_i.touch_threshold) begin
          phase_d = PH_IDLE;
          pos_d   = '0;
          entry_d = '0;
          lock_d  = '0;
          light_d = 1'b1;
          timer_d = '0;
          ev      = EV_OPENED;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.event_res      = ev;
    res_o.light_on       = light_d;
    res_o.phase          = phase_code(phase_d);
    res_o.digits_entered = pos_d;
    res_o.lockout_left   = lock_d;
    res_o.failures       = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      entry_q  <= '0;
      first_q  <= '0;
      stored_q <= CW'(MASTER_RESET);
      fail_q   <= '0;
      lock_q   <= '0;
      light_q  <= 1'b0;
      timer_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      entry_q  <= entry_d;
      first_q  <= first_d;
      stored_q <= stored_d;
      fail_q   <= fail_d;
      lock_q   <= lock_d;
      light_q  <= light_d;
      timer_q  <= timer_d;
    end
  end

endmodule

### rtl/keypad_code_lock_controller.sv
// ---------------------------------------------------------------------------
// keypad code lock controller
// datapath: a request is held in the input reg, then its result in the result reg
// throughput: 1 request per cycle while the result consumer keeps m_axis_tready high
// reset: rst_ni async low; idle phase, light off, counts cleared, default config
// ---------------------------------------------------------------------------
module keypad_code_lock_controller import kcl_pkg::*; #(
  parameter int unsigned CODE_LEN = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // func[1:0], key_code[5:2], touch_level[21:6], zero pad
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // event_res[2:0], light_on[3], phase[6:4],
                                      // digits_entered[10:7], lockout_left[22:11],
                                      // failures[30:23], zero pad
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i
);

`include "assert_macros.svh"

  cfg_t        cfg;
  res_t        res_next;

  // input register stage
  logic        in_valid_q, in_valid_d;
  logic [1:0]  in_func_q;
  logic [3:0]  in_key_q;
  logic [15:0] in_level_q;

  // result register stage
  logic        out_valid_q, out_valid_d;
  res_t        res_q;

  logic        out_free, advance;

  // the result slot frees when empty or when the consumer takes it; the
  // input stage drains into it in the same cycle, so both stay full at rate
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q  <= s_axis_tdata[1:0];
      in_key_q   <= s_axis_tdata[5:2];
      in_level_q <= s_axis_tdata[21:6];
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  kcl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // state commits only when the request moves into the result register
  kcl_core #(
    .CODE_LEN (CODE_LEN)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .func_i  (in_func_q),
    .key_i   (in_key_q),
    .level_i (in_level_q),
    .cfg_i   (cfg),
    .res_o   (res_next)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.failures, res_q.lockout_left, res_q.digits_entered,
                          res_q.phase, res_q.light_on, res_q.event_res};

  // a new result only appears after a request sat in the input stage
  `KCL_ASSERT(a_result_from_input, $rose(out_valid_q) |-> $past(in_valid_q), "result without request")
  // a free result slot must never stall the request side
  `KCL_ASSERT(a_ready_when_free, out_free |-> s_axis_tready, "request side stalled needlessly")
  // gathered key count stays below the code length
  `KCL_ASSERT(a_digits_range, out_valid_q |-> ({1'b0, res_q.digits_entered} < 5'(CODE_LEN)), "digit count overflow")
  // a locked phase always carries remaining lockout time
  `KCL_ASSERT_NEVER(a_locked_time, out_valid_q && res_q.phase == PHC_LOCKED && res_q.lockout_left == '0, "locked with no time left")

endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// keypad code lock controller testbench
// drives key, second-tick, backlight-tick and touch requests through the
// request stream, predicts every lock status result with a behavioral copy of
// the lock, and checks each status word field by field as it leaves the block
// ---------------------------------------------------------------------------
module tb import kcl_pkg::*;;

  localparam int CODE_LEN      = 10;    // keys per code, 4 bits each
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int MAX_MISMATCH  = 200;   // keep the log readable

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;

  // request side, driven at the falling edge
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [23:0] req_data  = '0;   // func[1:0], key_code[5:2], touch_level[21:6], zero pad

  // result side
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [31:0] res_data;         // event_res[2:0], light_on[3], phase[6:4],
                                 // digits_entered[10:7], lockout_left[22:11],
                                 // failures[30:23], zero pad

  // configuration channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [39:0] cfg_data  = '0;

  // run control and bookkeeping
  bit          idle_en = 1'b1;   // random gaps on both streams
  int unsigned errors;
  int unsigned reqs_sent;
  int unsigned results_checked;
  int unsigned event_seen [8];
  int unsigned quiet_cycles;
  int unsigned stall_left;

  // lock status words still owed by the block, oldest first
  res_t        lock_status_q [$];

  // behavioral copy of the configuration
  logic [39:0] master_word;
  logic [7:0]  fail_allow;
  logic [3:0]  lock_step;
  logic [7:0]  light_max;
  logic [15:0] touch_thr;

  // behavioral copy of the lock state
  logic [2:0]  lock_phase;
  logic [3:0]  keys_held;
  logic [39:0] entry_word;
  logic [39:0] first_word;
  logic [39:0] saved_code;
  logic [7:0]  fail_cnt;
  logic [11:0] lock_secs;
  logic        light_q;
  logic [7:0]  light_age;

  keypad_code_lock_controller #(
    .CODE_LEN(CODE_LEN)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(req_valid),
    .s_axis_tready(req_ready),
    .s_axis_tdata (req_data),
    .m_axis_tvalid(res_valid),
    .m_axis_tready(res_ready),
    .m_axis_tdata (res_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lock predictor
  // ---------------------------------------------------------------------------

  // shift one key into the entry; star and hash are skipped
  // returns 1 when a full code has been gathered
  function automatic bit gather_key(logic [3:0] k);
    if (k == KEY_STAR || k == KEY_HASH) return 1'b0;
    entry_word = {entry_word[35:0], k};
    keys_held  = keys_held + 4'd1;
    if (keys_held >= 4'(CODE_LEN)) begin
      keys_held = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the lock by one request and return the status word it must report
  function automatic res_t predict_lock_status(logic [1:0] fn, logic [3:0] k,
                                               logic [15:0] lvl);
    event_e ev;
    res_t   r;
    ev = EV_NONE;
    case (fn)
      FUNC_KEY: if (lock_phase != PHC_LOCKED) begin
        // any key outside the lockout lights the backlight
        light_q   = 1'b1;
        light_age = '0;
        case (lock_phase)
          PHC_IDLE: begin
            // first key only picks the mode
            lock_phase = (k == KEY_STAR) ? PHC_CHECK : PHC_UNLOCK;
            keys_held  = '0;
            entry_word = '0;
          end
          PHC_UNLOCK: if (gather_key(k)) begin
            lock_phase = PHC_IDLE;
            if (entry_word == saved_code) begin
              fail_cnt = '0;
              ev       = EV_OPENED;
            end else begin
              if (fail_cnt != 8'hFF) fail_cnt = fail_cnt + 8'd1;
              ev = EV_WRONG;
              // a zero step gives a zero lockout, so none starts
              if (fail_cnt > fail_allow && lock_step != 4'd0) begin
                lock_secs  = lock_step * fail_cnt;
                lock_phase = PHC_LOCKED;
                ev         = EV_LOCK_BEGIN;
              end
            end
          end
          PHC_CHECK: if (gather_key(k)) begin
            // either the stored code or the master code opens a change
            if (entry_word == saved_code || entry_word == master_word) begin
              lock_phase = PHC_NEW;
              entry_word = '0;
            end else begin
              lock_phase = PHC_IDLE;
              ev         = EV_WRONG;
            end
          end
          PHC_NEW: if (gather_key(k)) begin
            first_word = entry_word;
            entry_word = '0;
            lock_phase = PHC_CONFIRM;
          end
          default: if (gather_key(k)) begin
            lock_phase = PHC_IDLE;
            if (entry_word == first_word) begin
              saved_code = entry_word;
              ev         = EV_CHANGED;
            end else begin
              ev = EV_DIFFER;
            end
          end
        endcase
      end
      FUNC_SECOND: if (lock_phase == PHC_LOCKED) begin
        if (lock_secs != '0) lock_secs = lock_secs - 12'd1;
        if (lock_secs == '0) begin
          lock_phase = PHC_IDLE;
          ev         = EV_LOCK_OVER;
        end
      end
      FUNC_LIGHT: if (light_q) begin
        if (light_age > light_max) begin
          light_age = '0;
          light_q   = 1'b0;
        end else if (light_age != 8'hFF) begin
          light_age = light_age + 8'd1;
        end
      end
      default: if (lvl < touch_thr) begin
        // touch aborts any entry or lockout but keeps the failure count
        lock_phase = PHC_IDLE;
        keys_held  = '0;
        entry_word = '0;
        lock_secs  = '0;
        light_q    = 1'b1;
        light_age  = '0;
        ev         = EV_OPENED;
      end
    endcase
    r.event_res      = ev;
    r.light_on       = light_q;
    r.phase          = lock_phase;
    r.digits_entered = keys_held;
    r.lockout_left   = lock_secs;
    r.failures       = fail_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [11:0] want_v, logic [11:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      if (errors <= MAX_MISMATCH)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    res_t seen;
    if (rst_ni && res_valid && res_ready) begin
      if (lock_status_q.size() == 0) begin
        errors++;
        $display("%0t: status word %h with no request outstanding, expected none",
                 $time, res_data);
      end else begin
        want = lock_status_q.pop_front();
        seen = res_t'(res_data[30:0]);
        check_field("event_res",      want.event_res,      seen.event_res);
        check_field("light_on",       want.light_on,       seen.light_on);
        check_field("phase",          want.phase,          seen.phase);
        check_field("digits_entered", want.digits_entered, seen.digits_entered);
        check_field("lockout_left",   want.lockout_left,   seen.lockout_left);
        check_field("failures",       want.failures,       seen.failures);
        check_field("pad bit",        12'd0,               res_data[31]);
        results_checked++;
      end
    end
  end

  // random result stall bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      res_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      res_ready  <= 1'b1;
    end
  end

  // watchdog on cycles where no channel moves anything
  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d status words outstanding",
               $time, STALL_LIMIT, lock_status_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // send one request; valid stays high on return so back-to-back requests flow
  task automatic send_req(logic [1:0] fn, logic [3:0] k, logic [15:0] lvl);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    req_valid = 1'b1;
    req_data  = {2'b00, lvl, k, fn};
    do @(posedge clk_i); while (!req_ready);
    lock_status_q.push_back(predict_lock_status(fn, k, lvl));
    event_seen[lock_status_q[$].event_res]++;
    reqs_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_key(logic [3:0] k);
    send_req(FUNC_KEY, k, 16'($urandom));
  endtask

  task automatic send_tick(logic [1:0] fn);
    send_req(fn, 4'($urandom), 16'($urandom));
  endtask

  task automatic send_touch(logic [15:0] lvl);
    send_req(FUNC_TOUCH, 4'($urandom), lvl);
  endtask

  // hold off requests until every status word has come back
  task automatic wait_drained();
    req_valid = 1'b0;
    while (lock_status_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [39:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_MASTER_CODE:     master_word = val;
      CFG_FAIL_LIMIT:      fail_allow  = val[7:0];
      CFG_LOCKOUT_STEP:    lock_step   = val[3:0];
      CFG_LIGHT_TICKS:     light_max   = val[7:0];
      CFG_TOUCH_THRESHOLD: touch_thr   = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // codes made of enterable keys only (digits and A-D)
  function automatic logic [39:0] rand_code();
    logic [39:0] c;
    for (int i = 0; i < CODE_LEN; i++) c[4*i +: 4] = 4'($urandom_range(0, 13));
    return c;
  endfunction

  // same code with exactly one key changed
  function automatic logic [39:0] near_miss(logic [39:0] c);
    int unsigned pos;
    logic [3:0]  d;
    pos = $urandom_range(0, CODE_LEN - 1);
    d   = 4'($urandom_range(0, 13));
    if (d == c[4*pos +: 4]) d = (d == 4'd13) ? 4'd0 : d + 4'd1;
    c[4*pos +: 4] = d;
    return c;
  endfunction

  // opening key: star for a code change, any other key for an unlock
  task automatic start_entry(bit change);
    logic [3:0] k;
    k = 4'($urandom_range(0, 14));
    if (k == KEY_STAR) k = KEY_HASH;
    send_key(change ? KEY_STAR : k);
  endtask

  // type a code first key first, now and then with a stray star or hash
  task automatic enter_code(logic [39:0] c);
    for (int i = CODE_LEN - 1; i >= 0; i--) begin
      if ($urandom_range(0, 9) == 0) send_key($urandom_range(0, 1) ? KEY_STAR : KEY_HASH);
      send_key(c[4*i +: 4]);
    end
  endtask

  // leave the lockout by counting it down or, if allowed, by a touch
  task automatic ride_out_lockout(bit allow_touch);
    int unsigned n;
    n = $urandom_range(0, 12);
    while (lock_phase == PHC_LOCKED) begin
      case ($urandom_range(0, 9))
        0: send_key(4'($urandom));   // ignored while locked
        1: send_tick(FUNC_LIGHT);
        default: begin
          if (allow_touch && n == 0 && touch_thr != '0)
            send_touch(16'($urandom_range(0, touch_thr - 1)));
          else
            send_tick(FUNC_SECOND);
          if (n != 0) n--;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset configuration: unlock with the reset code, ignored ticks, touches
  task automatic test_directed();
    logic [3:0] seq [13] = '{4'd5, 4'd2, 4'd0, 4'd8, KEY_STAR, 4'd2, 4'd1, KEY_HASH,
                             4'd9, 4'd9, 4'd7, 4'd12, 4'd13};
    send_tick(FUNC_SECOND);           // outside the lockout, ignored
    send_tick(FUNC_LIGHT);            // light still off
    foreach (seq[i]) send_key(seq[i]);
    send_tick(FUNC_LIGHT);
    send_touch(TOUCH_THR_RST);        // level equal to threshold is no touch
    send_touch(16'hFFFF);
    send_key(4'd0);
    send_key(4'd3);
    send_touch(16'h0000);             // aborts the unlock entry
    send_key(KEY_STAR);
    send_touch(TOUCH_THR_RST - 16'd1);
    wait_drained();
  endtask

  // right, wrong and near-miss unlocks with short lockouts
  task automatic test_unlock_attempts(int unsigned tries);
    write_reg(CFG_MASTER_CODE, rand_code());
    write_reg(CFG_FAIL_LIMIT, 40'd2);
    write_reg(CFG_LOCKOUT_STEP, 40'($urandom_range(1, 3)));
    write_reg(CFG_LIGHT_TICKS, 40'd3);
    write_reg(CFG_TOUCH_THRESHOLD, 40'd1000);
    repeat (tries) begin
      if ($urandom_range(0, 4) == 0) send_tick($urandom_range(0, 1) ? FUNC_LIGHT : FUNC_SECOND);
      start_entry(1'b0);
      case ($urandom_range(0, 2))
        0:       enter_code(saved_code);
        1:       enter_code(near_miss(saved_code));
        default: enter_code(rand_code());
      endcase
      if (lock_phase == PHC_LOCKED) begin
        if ($urandom_range(0, 2) == 0) wait_drained();
        ride_out_lockout($urandom_range(0, 1));
      end
    end
  endtask

  // code changes through the stored and the master code, both confirm outcomes
  task automatic test_code_change(int unsigned seqs, logic [39:0] master);
    logic [39:0] fresh;
    write_reg(CFG_MASTER_CODE, master);
    write_reg(CFG_FAIL_LIMIT, 40'd255);
    write_reg(CFG_LOCKOUT_STEP, 40'd15);
    write_reg(CFG_LIGHT_TICKS, 40'd255);
    write_reg(CFG_TOUCH_THRESHOLD, 40'd0);   // no level can count as a touch
    repeat (seqs) begin
      send_touch(16'($urandom));
      start_entry(1'b1);
      case ($urandom_range(0, 3))
        0:       enter_code(saved_code);
        1:       enter_code(near_miss(saved_code));   // wrong code in change mode
        default: enter_code(master_word);
      endcase
      if (lock_phase == PHC_NEW) begin
        fresh = rand_code();
        enter_code(fresh);
        enter_code(($urandom_range(0, 2) == 0) ? near_miss(fresh) : fresh);
        if ($urandom_range(0, 1)) begin
          start_entry(1'b0);
          enter_code(saved_code);
        end
      end
    end
  endtask

  // backlight timeout at both ends of its range and in between
  task automatic test_backlight(int unsigned n);
    write_reg(CFG_TOUCH_THRESHOLD, 40'hFFFF);
    // the timer saturates at 255 and never exceeds a limit of 255, so the light stays on
    write_reg(CFG_LIGHT_TICKS, 40'd255);
    send_touch(16'h0000);
    repeat (258) send_tick(FUNC_LIGHT);
    for (int pass = 0; pass < 2; pass++) begin
      write_reg(CFG_LIGHT_TICKS, (pass == 0) ? 40'd0 : 40'd6);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1:    send_key(4'($urandom));
          2:       send_touch(16'($urandom_range(0, 16'hFFFE)));
          3:       send_touch(16'hFFFF);
          default: send_tick(FUNC_LIGHT);
        endcase
      end
    end
  endtask

  // mostly unstructured requests with zero lockout step and zero fail limit
  task automatic test_random_mix(int unsigned n);
    logic [1:0] fn;
    write_reg(CFG_MASTER_CODE, 40'hFF_FFFF_FFFF);
    write_reg(CFG_FAIL_LIMIT, 40'd0);
    write_reg(CFG_LOCKOUT_STEP, 40'd0);
    write_reg(CFG_TOUCH_THRESHOLD, 40'($urandom_range(1000, 30000)));
    send_touch(16'h0000);
    start_entry(1'b0);
    enter_code(near_miss(saved_code));   // failure with a zero-length lockout
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin
          start_entry(1'b0);
          enter_code($urandom_range(0, 1) ? saved_code : near_miss(saved_code));
        end
        1: send_key(KEY_STAR);
        default: begin
          fn = 2'($urandom);
          if (fn == FUNC_TOUCH && $urandom_range(0, 1))
            send_touch(16'($urandom_range(0, touch_thr - 1)));
          else
            send_req(fn, 4'($urandom), 16'($urandom));
        end
      endcase
    end
  endtask

  // a run of failures, then a long lockout forced by lowering the limit
  task automatic test_fail_lockout(int unsigned misses);
    write_reg(CFG_FAIL_LIMIT, 40'd255);
    write_reg(CFG_LOCKOUT_STEP, 40'd15);
    write_reg(CFG_TOUCH_THRESHOLD, 40'(TOUCH_THR_RST));
    send_touch(16'h0000);
    repeat (misses) begin
      start_entry(1'b0);
      enter_code(near_miss(saved_code));
    end
    write_reg(CFG_FAIL_LIMIT, 40'(fail_cnt));
    start_entry(1'b0);
    enter_code(near_miss(saved_code));   // lockout of 15 seconds per failure
    repeat (20) send_tick(FUNC_SECOND);
    send_key(4'd1);
    send_touch(16'h0000);
    start_entry(1'b0);
    enter_code(saved_code);              // clears the failure count
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    master_word = MASTER_RESET;
    fail_allow  = FAIL_LIMIT_RST;
    lock_step   = LOCK_STEP_RST;
    light_max   = LIGHT_TICKS_RST;
    touch_thr   = TOUCH_THR_RST;
    lock_phase  = PHC_IDLE;
    keys_held   = '0;
    entry_word  = '0;
    first_word  = '0;
    saved_code  = MASTER_RESET;
    fail_cnt    = '0;
    lock_secs   = '0;
    light_q     = 1'b0;
    light_age   = '0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_unlock_attempts(5);
    idle_en = 1'b0;
    test_code_change(2, rand_code());
    test_code_change(1, 40'd0);
    idle_en = 1'b1;
    test_backlight(12);
    test_random_mix(40);
    idle_en = 1'b0;
    test_fail_lockout(3);

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("run: %0d requests, %0d status words checked, %0d mismatches",
             reqs_sent, results_checked, errors);
    $display("events: %0d opened, %0d wrong, %0d changed, %0d differ, %0d lockouts, %0d over",
             event_seen[EV_OPENED], event_seen[EV_WRONG], event_seen[EV_CHANGED],
             event_seen[EV_DIFFER], event_seen[EV_LOCK_BEGIN], event_seen[EV_LOCK_OVER]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
